// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset
`define TTCW_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Condition must never be seen outside reset
`define TTCW_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define TTCW_ASSERT(name, clk, rst_n, prop)
`define TTCW_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

// ----- rtl/core/ttcw_pkg.sv -----
// Package: geometry, character codes, payload and control types of the terminal cell writer
package ttcw_pkg;

  localparam int unsigned ROWS        = 16;
  localparam int unsigned COLS        = 40;
  localparam int unsigned ESC_BUF_LEN = 16;

  localparam int unsigned CELLS     = ROWS * COLS;
  localparam int unsigned ADDR_W    = $clog2(CELLS);
  localparam int unsigned ESC_CNT_W = $clog2(ESC_BUF_LEN);

  localparam int unsigned ROW_W  = 4;
  localparam int unsigned COL_W  = 6;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned BYTE_W = 8;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [BYTE_W-1:0] BYTE_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] BYTE_ESC   = 8'h1B;
  localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] BYTE_TWO   = 8'h32;
  localparam logic [BYTE_W-1:0] BYTE_UC_A  = 8'h41;
  localparam logic [BYTE_W-1:0] BYTE_UC_J  = 8'h4A;
  localparam logic [BYTE_W-1:0] BYTE_UC_Z  = 8'h5A;
  localparam logic [BYTE_W-1:0] BYTE_LC_A  = 8'h61;
  localparam logic [BYTE_W-1:0] BYTE_LC_Z  = 8'h7A;
  localparam logic [BYTE_W-1:0] BYTE_DEL   = 8'h7F;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] byte_in;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] read_char;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic              cell_written;
    logic [ROW_W-1:0]  written_row;
    logic [COL_W-1:0]  written_col;
    logic [CHAR_W-1:0] written_char;
    logic              scrolled;
    logic              cleared;
    logic              in_escape;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic take;      // input transaction completes this cycle
    logic sweep_en;  // blank one cell at the sweep address
    logic out_load;  // move the pending result into the output register
  } ttcw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_sweep;  // item at the input scrolls or clears
    logic sweep_last;  // sweep address is at its last cell
  } ttcw_sts_t;

  typedef enum logic [3:0] {
    ST_INIT  = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_BLANK = 4'b0100,
    ST_DONE  = 4'b1000
  } ctrl_state_e;

endpackage

// ----- rtl/core/ttcw_ctrl.sv -----
// Controller: sequences item intake, blanking sweeps and result handoff
module ttcw_ctrl
  import ttcw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  ttcw_sts_t sts_i,
  output ttcw_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.sweep_en = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = sts_i.need_sweep ? ST_BLANK : ST_DONE;
        end
      end
      ST_BLANK: begin
        cmd_o.sweep_en = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/ttcw_datapath.sv -----
// Datapath: cursor and escape state, character store, sweep counter and result registers
module ttcw_datapath
  import ttcw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ttcw_cmd_t cmd_i,
  output ttcw_sts_t sts_o,
  input  in_item_t  in_data_i,
  output out_item_t out_data_o
);

  localparam int unsigned ROW_SUM_W = ROW_W + 1;

  // ring-mapped cell address of a logical row and column
  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] row,
                                                  logic [ROW_W-1:0] top,
                                                  logic [COL_W-1:0] col);
    logic [ROW_SUM_W-1:0] sum;
    logic [ROW_W-1:0]     phys;
    sum = {1'b0, row} + {1'b0, top};
    if (int'(sum) >= ROWS) begin
      sum = sum - ROW_SUM_W'(ROWS);
    end
    phys = sum[ROW_W-1:0];
    return ADDR_W'(phys) * ADDR_W'(COLS) + ADDR_W'(col);
  endfunction

  logic [CHAR_W-1:0] mem [CELLS];
  logic [CHAR_W-1:0] rdata_q;

  logic [ROW_W-1:0]     top_q, top_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic                 esc_q, esc_d;
  logic [ESC_CNT_W-1:0] cnt_q, cnt_d;
  logic                 two_q, two_d;
  logic [ADDR_W-1:0]    sweep_addr_q, sweep_addr_d;
  logic [ADDR_W-1:0]    sweep_end_q, sweep_end_d;

  logic [BYTE_W-1:0] b;
  logic              is_letter;
  logic              stored;
  logic              step_row;
  logic              scroll;
  logic              clear;
  logic              wr_en;
  logic [COL_W-1:0]  wr_col;
  logic [CHAR_W-1:0] wr_char;
  logic              in_range;
  logic [ADDR_W-1:0] acc_addr;
  logic [ADDR_W-1:0] blank_row_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic              rd_en;

  out_item_t res_q, res_d;
  logic      op_q;
  logic      in_range_q;
  out_item_t out_q, out_d;

  assign b         = in_data_i.byte_in;
  assign is_letter = (b >= BYTE_UC_A && b <= BYTE_UC_Z) || (b >= BYTE_LC_A && b <= BYTE_LC_Z);

  // next terminal state for the item at the input
  always_comb begin
    top_d    = top_q;
    row_d    = row_q;
    col_d    = col_q;
    esc_d    = esc_q;
    cnt_d    = cnt_q;
    two_d    = two_q;
    stored   = 1'b0;
    step_row = 1'b0;
    scroll   = 1'b0;
    clear    = 1'b0;
    wr_en    = 1'b0;
    wr_col   = col_q;
    wr_char  = CHAR_SPACE;
    if (in_data_i.op == OP_READ) begin
      // reads leave the state alone
    end else if (esc_q) begin
      if (int'(cnt_q) < ESC_BUF_LEN - 1) begin
        stored = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        two_d  = (b == BYTE_TWO);
      end
      if (is_letter) begin
        esc_d = 1'b0;
        cnt_d = '0;
        two_d = 1'b0;
        // erase-display only when J and the byte before it were both kept
        if (b == BYTE_UC_J && stored && two_q) begin
          clear = 1'b1;
          top_d = '0;
          row_d = '0;
          col_d = '0;
        end
      end
    end else if (b == BYTE_ESC) begin
      esc_d = 1'b1;
      cnt_d = '0;
      two_d = 1'b0;
    end else if (b == BYTE_CR) begin
      col_d = '0;
    end else if (b == BYTE_LF) begin
      col_d    = '0;
      step_row = 1'b1;
    end else if (b == BYTE_BS || b == BYTE_DEL) begin
      if (col_q != '0) begin
        col_d  = col_q - 1'b1;
        wr_en  = 1'b1;
        wr_col = col_q - 1'b1;
      end
    end else if (b >= BYTE_SPACE && b < BYTE_DEL) begin
      wr_en   = 1'b1;
      wr_char = b[CHAR_W-1:0];
      if (int'(col_q) == COLS - 1) begin
        col_d    = '0;
        step_row = 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
    if (step_row) begin
      if (int'(row_q) == ROWS - 1) begin
        scroll = 1'b1;
        top_d  = (int'(top_q) == ROWS - 1) ? '0 : top_q + 1'b1;
      end else begin
        row_d = row_q + 1'b1;
      end
    end
  end

  assign in_range = (int'(in_data_i.read_row) < ROWS) && (int'(in_data_i.read_col) < COLS);
  assign acc_addr = (in_data_i.op == OP_READ)
                  ? cell_addr(in_data_i.read_row, top_q, in_data_i.read_col)
                  : cell_addr(row_q, top_q, wr_col);

  // after a scroll the old top row becomes the bottom row
  assign blank_row_addr = ADDR_W'(top_q) * ADDR_W'(COLS);

  always_comb begin
    sweep_addr_d = sweep_addr_q;
    sweep_end_d  = sweep_end_q;
    if (cmd_i.sweep_en) begin
      sweep_addr_d = sweep_addr_q + 1'b1;
    end else if (cmd_i.take && clear) begin
      sweep_addr_d = '0;
      sweep_end_d  = ADDR_W'(CELLS - 1);
    end else if (cmd_i.take && scroll) begin
      sweep_addr_d = blank_row_addr;
      sweep_end_d  = blank_row_addr + ADDR_W'(COLS - 1);
    end
  end

  assign sts_o.need_sweep = scroll || clear;
  assign sts_o.sweep_last = (sweep_addr_q == sweep_end_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q        <= '0;
      row_q        <= '0;
      col_q        <= '0;
      esc_q        <= 1'b0;
      cnt_q        <= '0;
      two_q        <= 1'b0;
      sweep_addr_q <= '0;
      sweep_end_q  <= ADDR_W'(CELLS - 1);
    end else begin
      if (cmd_i.take) begin
        top_q <= top_d;
        row_q <= row_d;
        col_q <= col_d;
        esc_q <= esc_d;
        cnt_q <= cnt_d;
        two_q <= two_d;
      end
      sweep_addr_q <= sweep_addr_d;
      sweep_end_q  <= sweep_end_d;
    end
  end

  assign mem_we    = cmd_i.sweep_en || (cmd_i.take && wr_en);
  assign mem_waddr = cmd_i.sweep_en ? sweep_addr_q : acc_addr;
  assign mem_wdata = cmd_i.sweep_en ? CHAR_SPACE : wr_char;
  assign rd_en     = cmd_i.take && (in_data_i.op == OP_READ);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[acc_addr];
    end
  end

  always_comb begin
    res_d              = '0;
    res_d.cursor_row   = row_d;
    res_d.cursor_col   = col_d;
    res_d.cell_written = wr_en;
    if (wr_en) begin
      res_d.written_row  = row_q;
      res_d.written_col  = wr_col;
      res_d.written_char = wr_char;
    end
    res_d.scrolled  = scroll;
    res_d.cleared   = clear;
    res_d.in_escape = esc_d;
  end

  // read data is registered at the take, so it joins the result here
  always_comb begin
    out_d           = res_q;
    out_d.read_char = (op_q == OP_READ) ? (in_range_q ? rdata_q : CHAR_SPACE) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      res_q      <= res_d;
      op_q       <= in_data_i.op;
      in_range_q <= in_range;
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- rtl/core/text_terminal_cell_writer_unit.sv -----
// Top level: character-cell text terminal writer with cell read-back
//
// Input channel (in_valid_i / in_ready_o / in_data_i): one transaction is one
// item. op = 0 feeds byte_in to the terminal (printable, CR, LF, BS/DEL, ESC
// sequences), op = 1 reads the logical cell at read_row/read_col.
// Output channel (out_valid_o / out_ready_i / out_data_o): one result per item,
// carrying the cursor after the item and what it wrote, scrolled or cleared.
// Flow: an item is taken in ST_IDLE and its result is registered in the
// datapath, then loaded into the output register in ST_DONE once that register
// is free. A scroll first blanks the COLS (40) cells of the new bottom row;
// ESC[2J first blanks all ROWS*COLS (640) cells of the store.
// Both walk the single-port write side of the character store one cell a cycle.
// Reset: cursor, ring offset and escape state go to zero, then a pass writes
// spaces into every cell; in_ready_o stays low until it ends.
// Stall: a result waits in the output register while the next item is taken;
// that item's result then holds in the datapath and in_ready_o stays low until
// the output register is free again.
`include "assert_macros.svh"

module text_terminal_cell_writer_unit
  import ttcw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  ttcw_cmd_t cmd;
  ttcw_sts_t sts;

  ttcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ttcw_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

  `TTCW_ASSERT(a_load_only_when_free, clk_i, rst_ni, cmd.out_load |-> (!out_valid_o || out_ready_i))
  `TTCW_ASSERT(a_load_shows_result, clk_i, rst_ni, cmd.out_load |=> out_valid_o)
  `TTCW_ASSERT_NEVER(a_no_intake_in_sweep, clk_i, rst_ni, cmd.sweep_en && in_ready_o)
  `TTCW_ASSERT(a_plain_item_no_sweep, clk_i, rst_ni, (cmd.take && !sts.need_sweep) |=> !cmd.sweep_en)

endmodule
